@@ rtl/poly_sine_synth_with_recorder_unit_assert.svh @@
// Assertion macros for the poly sine synthesizer unit.
// Included by the top level; no other dependencies.
`ifndef POLY_SINE_SYNTH_WITH_RECORDER_UNIT_ASSERT_SVH
`define POLY_SINE_SYNTH_WITH_RECORDER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSSR_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define PSSR_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define PSSR_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define PSSR_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

@@ rtl/pssr_pkg.sv @@
// Package for the poly sine synthesizer: item types, codes, note tables
// and the sine table generator. No dependencies.
`default_nettype none
package pssr_pkg;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_REC  = 2'd2;
    localparam logic [1:0] OP_PLAY = 2'd3;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic [1:0] CFG_DECAY = 2'd0;
    localparam logic [1:0] CFG_FULL  = 2'd1;
    localparam logic [1:0] CFG_WRAP  = 2'd2;

    localparam logic [23:0] DECAY_RESET = 24'd16773861;
    localparam logic [30:0] FULL_RESET  = 31'h7fffffff;
    localparam logic [15:0] WRAP_RESET  = 16'd8000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // phase increment per note, C4 up to C5; unused voices stand still
    localparam logic [31:0] NOTE_INC [16] = '{
        32'd140459389, 32'd148811489, 32'd157660196, 32'd167035036,
        32'd176967685, 32'd187490355, 32'd198639016, 32'd210450713,
        32'd222965174, 32'd236223201, 32'd250269892, 32'd265151417,
        32'd280918242, 32'd0, 32'd0, 32'd0
    };

    // key code per voice; bit 16 set means no key
    localparam logic [16:0] NOTE_KEY [16] = '{
        17'h10, 17'h03, 17'h11, 17'h04, 17'h12, 17'h13, 17'h06, 17'h14,
        17'h07, 17'h15, 17'h08, 17'h16, 17'h17, 17'h10000, 17'h10000, 17'h10000
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] key_code;
        logic [1:0]  key_action;
        logic        hundredth_passed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_valid;
        logic [1:0]         mode;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_KEY  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_REC  = 2'd2,
        CMD_PLAY = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic       key_hit;
        logic       key_press;
        logic [3:0] voice;
        logic       hundredth;
    } t_cmd;

    typedef struct packed {
        logic [23:0] decay_factor;
        logic [30:0] full_volume;
        logic [15:0] wrap_length;
    } t_cfg;

    // Q30 Taylor sine over the first quadrant, mirrored, scaled to 32767
    function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                      input int unsigned tb);
        logic [63:0]        quarter;
        logic [63:0]        q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic [63:0]        outv;
        logic signed [63:0] sum;
        quarter = 64'd1 << (tb - 2);
        q = (64'(k) >> (tb - 2)) & 64'd3;
        r = 64'(k) & (quarter - 64'd1);
        if (q[0]) begin
            r = quarter - r;
        end
        x   = (r * HALF_PI_Q30) >> (tb - 2);
        x2  = (x * x) >> 30;
        mag = x;
        sum = $signed(x);
        mag = ((mag * x2) >> 30) / 64'd6;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + $signed(mag);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        outv = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q >= 64'd2) begin
            return -$signed(outv[15:0]);
        end
        return $signed(outv[15:0]);
    endfunction

endpackage
`default_nettype wire

@@ rtl/pssr_front.sv @@
// Front end: decodes an input item into a back-end command.
// Depends on pssr_pkg.
`default_nettype none
module pssr_front #(
    parameter int NUM_VOICES = 13
) (
    input  wire pssr_pkg::t_in_item i_item,
    output pssr_pkg::t_cmd          o_cmd
);
    import pssr_pkg::*;

    logic       w_hit;
    logic [3:0] w_voice;

    // key code to voice lookup; codes are unique
    always_comb begin
        w_hit   = 1'b0;
        w_voice = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (NOTE_KEY[v] == {1'b0, i_item.key_code}) begin
                w_hit   = 1'b1;
                w_voice = 4'(v);
            end
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.hundredth = i_item.hundredth_passed;
        o_cmd.voice     = w_voice;
        o_cmd.key_press = (i_item.key_action == ACT_PRESS);
        // autorepeat and unknown actions count as misses
        o_cmd.key_hit   = w_hit && (i_item.key_action == ACT_PRESS ||
                                    i_item.key_action == ACT_RELEASE);
        case (i_item.opcode)
            OP_KEY:  o_cmd.kind = CMD_KEY;
            OP_TICK: o_cmd.kind = CMD_TICK;
            OP_REC:  o_cmd.kind = CMD_REC;
            OP_PLAY: o_cmd.kind = CMD_PLAY;
            default: o_cmd.kind = CMD_KEY;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/pssr_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on pssr_pkg.
`default_nettype none
module pssr_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire pssr_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  wire               i_pop,
    output pssr_pkg::t_cmd    o_cmd,
    output logic              o_empty
);
    import pssr_pkg::*;

    t_cmd       r_slot [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/pssr_back.sv @@
// Back end: voice state, sine table, per-voice mix pipeline, recorder
// memory and result register. Depends on pssr_pkg.
`default_nettype none
module pssr_back #(
    parameter int NUM_VOICES      = 13,
    parameter int STORE_ROWS      = 2048,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire pssr_pkg::t_cfg  i_cfg,
    input  wire pssr_pkg::t_cmd  i_cmd,
    input  wire                  i_cmd_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pssr_pkg::t_out_item  o_out_data
);
    import pssr_pkg::*;

    localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int RW  = $clog2(STORE_ROWS);
    localparam int RCW = RW + 1;
    localparam int AW  = RW + VW;
    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
    localparam logic [RCW-1:0] ROW_LIMIT = RCW'(STORE_ROWS);
    localparam logic [VW-1:0]  LAST_V = VW'(NUM_VOICES - 1);
    // floor(x / NUM_VOICES) = (x * RECIP) >> 35 for x below 2^31
    localparam logic [35:0] RECIP =
        36'(((64'd1 << 35) + 64'(NUM_VOICES) - 64'd1) / 64'(NUM_VOICES));

    typedef logic signed [15:0] t_sine_rom [TABLE_SIZE];

    function automatic t_sine_rom build_rom();
        t_sine_rom t;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            t[k] = sine_entry(k, SINE_TABLE_BITS);
        end
        return t;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state          r_state;
    logic [30:0]     r_amp   [NUM_VOICES];
    logic [31:0]     r_phase [NUM_VOICES];
    logic [15:0]     r_counter;
    logic            r_recording;
    logic            r_playing;
    logic [RCW-1:0]  r_row;
    logic [RCW-1:0]  r_recorded;
    logic [VW-1:0]   r_v;

    // per-tick flags
    logic            r_t_tick;
    logic            r_t_have;
    logic            r_t_write;
    logic            r_t_adv;
    logic            r_t_wrap;
    logic signed [31:0] r_acc;

    // mix pipeline
    logic            r_s1_vld;
    logic [VW-1:0]   r_s1_v;
    logic [30:0]     r_s1_amp;
    logic signed [15:0] r_s1_sine;
    logic            r_s2_vld;
    logic [VW-1:0]   r_s2_v;
    logic signed [46:0] r_s2_prod;
    logic [30:0]     r_s2_dec;
    logic            r_s3_vld;
    logic            r_s3_neg;
    logic [66:0]     r_s3_mq;

    logic [30:0]     r_mem [1 << AW];
    logic [30:0]     r_mem_q;

    logic            r_out_vld;
    t_out_item       r_out;

    logic [15:0]     w_cnt_inc;
    logic            w_wrap;
    logic [30:0]     w_amp_eff;
    logic signed [46:0] w_prod;
    logic [54:0]     w_dec;
    logic [46:0]     w_abs;
    logic [30:0]     w_quot;
    logic            w_slot_free;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_waddr;
    logic            w_we;
    logic [1:0]      w_mode;

    assign o_pop       = (r_state == S_IDLE) && !i_cmd_empty;
    assign w_slot_free = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign w_mode      = r_recording ? MODE_REC : (r_playing ? MODE_PLAY : MODE_IDLE);

    assign w_cnt_inc = r_counter + 16'd1;
    assign w_wrap    = (w_cnt_inc >= i_cfg.wrap_length) || (i_cfg.wrap_length == 16'd0);

    assign w_amp_eff = r_playing ? (r_t_have ? r_mem_q : 31'd0) : r_s1_amp;
    assign w_prod    = $signed({16'd0, w_amp_eff}) * $signed({{31{r_s1_sine[15]}}, r_s1_sine});
    assign w_dec     = {24'd0, r_s1_amp} * {31'd0, i_cfg.decay_factor};
    assign w_abs     = r_s2_prod[46] ? 47'(-r_s2_prod) : 47'(r_s2_prod);
    assign w_quot    = r_s3_mq[65:35];

    assign w_raddr = {r_row[RW-1:0], r_v};
    assign w_waddr = {r_row[RW-1:0], r_s2_v};
    assign w_we    = r_s2_vld && r_t_write;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_s2_dec;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_s1_v    <= r_v;
        r_s1_amp  <= r_amp[r_v];
        r_s1_sine <= SINE_ROM[r_phase[r_v][31 -: SINE_TABLE_BITS]];
        r_s2_v    <= r_s1_v;
        r_s2_prod <= w_prod;
        r_s2_dec  <= w_dec[54:24];
        r_s3_neg  <= r_s2_prod[46];
        r_s3_mq   <= {36'd0, w_abs[45:15]} * {31'd0, RECIP};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_recording <= 1'b0;
            r_playing   <= 1'b0;
            r_row       <= '0;
            r_recorded  <= '0;
            r_v         <= '0;
            r_t_tick    <= 1'b0;
            r_t_have    <= 1'b0;
            r_t_write   <= 1'b0;
            r_t_adv     <= 1'b0;
            r_t_wrap    <= 1'b0;
            r_acc       <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_out       <= '0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_amp[v]   <= '0;
                r_phase[v] <= '0;
            end
        end else begin
            r_s1_vld <= (r_state == S_RUN);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_s2_vld && !r_playing) begin
                r_amp[r_s2_v] <= r_s2_dec;
            end
            if (r_s3_vld) begin
                r_acc <= r_s3_neg ? r_acc - $signed({1'b0, w_quot})
                                  : r_acc + $signed({1'b0, w_quot});
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_t_tick <= 1'b0;
                        r_state  <= S_DONE;
                        case (i_cmd.kind)
                            CMD_KEY: begin
                                if (!r_playing && i_cmd.key_hit) begin
                                    r_amp[i_cmd.voice[VW-1:0]] <=
                                        i_cmd.key_press ? i_cfg.full_volume : 31'd0;
                                end
                            end
                            CMD_TICK: begin
                                r_t_tick  <= 1'b1;
                                r_state   <= S_RUN;
                                r_v       <= '0;
                                r_acc     <= '0;
                                r_t_wrap  <= w_wrap;
                                r_counter <= w_wrap ? 16'd0 : w_cnt_inc;
                                r_t_have  <= (r_row < r_recorded) && (r_row < ROW_LIMIT);
                                r_t_write <= i_cmd.hundredth && r_recording &&
                                             !r_playing && (r_row < ROW_LIMIT);
                                r_t_adv   <= i_cmd.hundredth && (r_row < ROW_LIMIT) &&
                                             (r_playing || r_recording);
                            end
                            CMD_REC: begin
                                if (!r_playing) begin
                                    r_recording <= !r_recording;
                                    r_recorded  <= r_recording ? r_row : '0;
                                    r_row       <= '0;
                                end
                            end
                            CMD_PLAY: begin
                                if (!r_recording) begin
                                    r_playing <= !r_playing;
                                    if (!r_playing) begin
                                        r_row <= '0;
                                    end
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RUN: begin
                    // phase read for the sine lookup happens this cycle too
                    r_phase[r_v] <= r_t_wrap ? 32'd0
                                             : r_phase[r_v] + NOTE_INC[4'(r_v)];
                    if (r_v == LAST_V) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_v <= r_v + VW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_vld          <= 1'b1;
                        r_out.sample_value <= r_t_tick ? r_acc : 32'sd0;
                        r_out.sample_valid <= r_t_tick;
                        r_out.mode         <= w_mode;
                        if (r_t_tick && r_t_adv) begin
                            r_row <= r_row + RCW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/poly_sine_synth_with_recorder_unit.sv @@
// Top level of the poly sine synthesizer with amplitude recorder.
// Depends on pssr_pkg, pssr_front, pssr_queue, pssr_back and the assert header.
//
// Usage:
//  - Input channel i_in_valid / o_in_stall / i_in_data carries one item per
//    handshake: key event, sample tick, record button or playback button.
//  - Output channel o_out_valid / i_out_stall / o_out_data returns exactly one
//    item per input item, in order: the mixed sample on ticks, zero otherwise,
//    and the mode after that item.
//  - Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//    (decay factor, full volume, wrap length). Write only while idle.
//  - Timing: for a key or button item the back end goes from idle to its
//    done state and registers the result; for a sample tick it first steps
//    one voice per cycle through a four-stage mix pipeline (sine lookup and
//    memory read, multiply, divide by reciprocal, sum) and drains it.
//  - Throughput: one item at a time in the back end; a two-entry queue
//    takes new items while the back end works or its result waits.
//  - Reset (synchronous, active low) clears voices, phases, counters, modes
//    and the queue. The recorder memory is not cleared; only rows written
//    by a recording are ever played.
//  - A stalled result holds in the output register; the back end then
//    waits, the queue fills and o_in_stall rises.
`default_nettype none
`include "poly_sine_synth_with_recorder_unit_assert.svh"
module poly_sine_synth_with_recorder_unit #(
    parameter int NUM_VOICES      = 13,
    parameter int STORE_ROWS      = 2048,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire pssr_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output pssr_pkg::t_out_item     o_out_data,
    input  wire                     i_cfg_we,
    input  wire [1:0]               i_cfg_index,
    input  wire [30:0]              i_cfg_data
);
    import pssr_pkg::*;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    logic w_full;
    logic w_empty;
    logic w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_factor <= DECAY_RESET;
            r_cfg.full_volume  <= FULL_RESET;
            r_cfg.wrap_length  <= WRAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECAY: r_cfg.decay_factor <= i_cfg_data[23:0];
                CFG_FULL:  r_cfg.full_volume  <= i_cfg_data;
                CFG_WRAP:  r_cfg.wrap_length  <= i_cfg_data[15:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_in_stall = w_full;

    pssr_front #(
        .NUM_VOICES (NUM_VOICES)
    ) u_front (
        .i_item (i_in_data),
        .o_cmd  (w_front_cmd)
    );

    pssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    pssr_back #(
        .NUM_VOICES      (NUM_VOICES),
        .STORE_ROWS      (STORE_ROWS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_queue_cmd),
        .i_cmd_empty (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // non-sample results carry silence
    `PSSR_ASSERT_IMPL(a_silent_non_tick, i_clk, i_rst_n, o_out_valid && !o_out_data.sample_valid, o_out_data.sample_value == 32'sd0, "non-tick result carries a sample")
    // output mode code is never 3 (recording and playing never both active)
    `PSSR_ASSERT_IMPL(a_mode_code, i_clk, i_rst_n, o_out_valid, o_out_data.mode != 2'd3, "bad mode code")
    // a pop only ever happens from a non-empty queue
    `PSSR_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    // full queue with no pop stays full
    `PSSR_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, w_full && !w_pop, w_full, "queue lost an item")

endmodule
`default_nettype wire
